>>> rtl/core/skset_pkg.sv
// Shared types and codes for the sorted key set.
package skset_pkg;

  // Command codes; the unused code behaves as a find
  localparam logic [1:0] CMD_ADD    = 2'd0;
  localparam logic [1:0] CMD_REMOVE = 2'd1;
  localparam logic [1:0] CMD_FIND   = 2'd2;

  // Configuration register reset value
  localparam logic [6:0] CAPACITY_RST = 7'd64;

  // Width of the result position and count fields
  localparam int unsigned OUT_W = 7;

  typedef enum logic {
    ST_IDLE,
    ST_UPDATE
  } skset_state_t;

  // Shift control broadcast to every cell during the update cycle
  typedef struct packed {
    logic ins;   // open a slot at the insertion point and write the probe
    logic rem;   // close the gap at the matching entry
  } skset_shift_t;

endpackage

>>> rtl/core/skset_cell.sv
// One storage cell of the sorted key chain: compares and shifts its key.
module skset_cell
  import skset_pkg::*;
#(
  parameter int unsigned KEY_W = 64,
  parameter int unsigned CNT_W = 7,
  parameter int unsigned IDX   = 0
) (
  input  logic             clk,
  input  logic             cmp_en,
  input  logic [KEY_W-1:0] probe_in,
  input  logic [CNT_W-1:0] n,
  input  skset_shift_t     upd,
  input  logic [KEY_W-1:0] probe_q,
  input  logic [KEY_W-1:0] left_key,
  input  logic [KEY_W-1:0] right_key,
  input  logic             left_lt,
  output logic [KEY_W-1:0] key_out,
  output logic             lt_out,
  output logic             eq_out
);

  localparam logic [CNT_W-1:0] IDX_C = CNT_W'(IDX);

  logic [KEY_W-1:0] key_q;
  logic             lt_q;
  logic             eq_q;
  logic             below;

  // Only entries under the count take part in the search
  assign below = (IDX_C < n);

  // Compare flags, taken at the input transfer
  always_ff @(posedge clk) begin
    if (cmp_en) begin
      lt_q <= below && (key_q < probe_in);
      eq_q <= below && (key_q == probe_in);
    end
  end

  // Shift: insert moves keys up from the left, remove pulls from the right
  always_ff @(posedge clk) begin
    if (upd.ins && !lt_q) begin
      key_q <= left_lt ? probe_q : left_key;
    end else if (upd.rem && !lt_q) begin
      key_q <= right_key;
    end
  end

  assign key_out = key_q;
  assign lt_out  = lt_q;
  assign eq_out  = eq_q;

endmodule

>>> rtl/core/sorted_key_set.sv
// Each item is compared in every cell at the input transfer; the shift and
// count update and the result load follow in the update state. A new item is
// accepted only in the idle state, once the previous item's count is final.
// A waiting result stalls the update cycle until the output register frees.
// Reset clears the element count and sets capacity to 64; stored keys are
// left as they are and only entries below the count are ever used.
module sorted_key_set
  import skset_pkg::*;
#(
  parameter int unsigned DEPTH     = 64,
  parameter int unsigned KEY_BYTES = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [6:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  cmd,
  input  logic [63:0] key,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        was_present,
  output logic        full_refused,
  output logic [6:0]  position,
  output logic [6:0]  count
);

  localparam int unsigned KEY_W = 8 * KEY_BYTES;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned CW    = (CNT_W > OUT_W) ? CNT_W : OUT_W;

  skset_state_t     state;
  skset_state_t     state_next;
  logic [6:0]       capacity;
  logic [CNT_W-1:0] element_count;
  logic [CNT_W-1:0] element_count_next;
  logic [1:0]       cmd_q;
  logic [KEY_W-1:0] probe_q;
  logic [KEY_W-1:0] probe_in;
  logic             in_xfer;
  logic             commit;
  skset_shift_t     upd;

  logic [KEY_W-1:0] key_w [DEPTH];
  logic [DEPTH+1:0] lt_w;
  logic [DEPTH-1:0] eq_w;
  logic [DEPTH:0]   bound;
  logic [CNT_W-1:0] pos;
  logic             present;
  logic             full;
  logic [CW-1:0]    cap_eff;
  logic [CW-1:0]    n_ext;
  logic [CW-1:0]    pos_ext;
  logic [CW-1:0]    cnt_ext;

  // Key bits above the key width are dropped
  assign probe_in = key[KEY_W-1:0];
  assign in_ready = (state == ST_IDLE);
  assign in_xfer  = in_valid && in_ready;
  assign commit   = (state == ST_UPDATE) && (!out_valid || out_ready);

  // Capacity register
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAPACITY_RST;
    end else if (cfg_we) begin
      capacity <= cfg_data;
    end
  end

  // Held command and probe
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      cmd_q   <= cmd;
      probe_q <= probe_in;
    end
  end

  // Cell chain; lt_w[0] is a virtual "below" flag ahead of cell 0
  assign lt_w[0]       = 1'b1;
  assign lt_w[DEPTH+1] = 1'b0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [KEY_W-1:0] lk;
    logic [KEY_W-1:0] rk;
    if (i == 0) begin : g_first
      assign lk = probe_q;
    end else begin : g_mid_l
      assign lk = key_w[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign rk = key_w[i];
    end else begin : g_mid_r
      assign rk = key_w[i+1];
    end
    skset_cell #(
      .KEY_W (KEY_W),
      .CNT_W (CNT_W),
      .IDX   (i)
    ) u_cell (
      .clk       (clk),
      .cmp_en    (in_xfer),
      .probe_in  (probe_in),
      .n         (element_count),
      .upd       (upd),
      .probe_q   (probe_q),
      .left_key  (lk),
      .right_key (rk),
      .left_lt   (lt_w[i]),
      .key_out   (key_w[i]),
      .lt_out    (lt_w[i+1]),
      .eq_out    (eq_w[i])
    );
  end

  // Flags form a thermometer; its edge marks the position
  always_comb begin
    for (int j = 0; j <= DEPTH; j++) begin
      bound[j] = lt_w[j] && !lt_w[j+1];
    end
  end

  always_comb begin
    pos = '0;
    for (int j = 0; j <= DEPTH; j++) begin
      if (bound[j]) begin
        pos = pos | CNT_W'(j);
      end
    end
  end

  assign present = |eq_w;

  // Fullness against the smaller of capacity and depth
  assign n_ext   = CW'(element_count);
  assign cap_eff = (CW'(capacity) > CW'(DEPTH)) ? CW'(DEPTH) : CW'(capacity);
  assign full    = (cmd_q == CMD_ADD) && (n_ext >= cap_eff);

  always_comb begin
    upd.ins = commit && (cmd_q == CMD_ADD) && !full && !present;
    upd.rem = commit && (cmd_q == CMD_REMOVE) && present;
  end

  always_comb begin
    element_count_next = element_count;
    if (upd.ins) begin
      element_count_next = element_count + CNT_W'(1);
    end else if (upd.rem) begin
      element_count_next = element_count - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      element_count <= '0;
    end else begin
      element_count <= element_count_next;
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_xfer) begin
          state_next = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        if (commit) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Output register
  assign pos_ext = CW'(pos);
  assign cnt_ext = CW'(element_count_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      was_present  <= present;
      full_refused <= full;
      position     <= pos_ext[OUT_W-1:0];
      count        <= cnt_ext[OUT_W-1:0];
    end
  end

`ifndef SYNTHESIS
  // A transfer always leads into the update cycle
  assert property (@(posedge clk) disable iff (rst)
    in_xfer |=> (state == ST_UPDATE))
    else $error("update cycle missing after input transfer");

  // The count moves by at most one per item
  assert property (@(posedge clk) disable iff (rst)
    commit |=> (element_count == $past(element_count) ||
                element_count == $past(element_count) + CNT_W'(1) ||
                element_count == $past(element_count) - CNT_W'(1)))
    else $error("element count jumped");

  // A pending result reports the current count
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (count == n_ext[OUT_W-1:0]))
    else $error("result count disagrees with held count");
`endif

endmodule
